[hdl/geic_pkg.sv]
// Package for the banked GPIO edge interrupt controller.
// Holds command and register-select codes, sizes and the queue entry type.
`timescale 1ns / 1ps
package geic_pkg;
  localparam int NUM_BANKS_DEF     = 3;
  localparam int PINS_PER_BANK_DEF = 32;
  localparam int PIN_NUM_W         = 7;
  localparam int BANK_STRIDE       = 32;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;
  localparam logic [1:0] CMD_CLAIM  = 2'd3;

  localparam logic [3:0] SEL_TYPE      = 4'd0;
  localparam logic [3:0] SEL_POLHI_SET = 4'd1;
  localparam logic [3:0] SEL_POLHI_CLR = 4'd2;
  localparam logic [3:0] SEL_POLLO_SET = 4'd3;
  localparam logic [3:0] SEL_POLLO_CLR = 4'd4;
  localparam logic [3:0] SEL_EN_SET    = 4'd5;
  localparam logic [3:0] SEL_EN_CLR    = 4'd6;
  localparam logic [3:0] SEL_ENABLE    = 4'd7;
  localparam logic [3:0] SEL_STATUS    = 4'd8;

  // Request after front-end decode.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  bank;
    logic        bank_ok;
    logic [3:0]  sel;
    logic [31:0] wdata;
    logic [31:0] levels;
  } req_t;
endpackage

[hdl/geic_if.sv]
// Valid/ready channel interfaces for the controller.
// Depends on nothing.
`timescale 1ns / 1ps
interface geic_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  bank;
  logic [3:0]  reg_select;
  logic [31:0] write_data;
  logic [31:0] pin_levels;
  modport source (output valid, cmd, bank, reg_select, write_data, pin_levels, input ready);
  modport sink (input valid, cmd, bank, reg_select, write_data, pin_levels, output ready);
endinterface

interface geic_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_out;
  logic        claim_valid;
  logic [6:0]  claim_pin;
  modport source (output valid, read_data, irq_out, claim_valid, claim_pin, input ready);
  modport sink (input valid, read_data, irq_out, claim_valid, claim_pin, output ready);
endinterface

[hdl/geic_front.sv]
// Front end: accept requests, mask to the pin width, check the bank.
// Depends on geic_pkg.
`timescale 1ns / 1ps
module geic_front #(
  parameter int NUM_BANKS     = geic_pkg::NUM_BANKS_DEF,
  parameter int PINS_PER_BANK = geic_pkg::PINS_PER_BANK_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_cmd,
  input  logic [1:0]      in_bank,
  input  logic [3:0]      in_reg_select,
  input  logic [31:0]     in_write_data,
  input  logic [31:0]     in_pin_levels,
  output logic            q_valid,
  input  logic            q_ready,
  output geic_pkg::req_t  q_req
);
  localparam logic [31:0] PIN_MASK = 32'((64'd1 << PINS_PER_BANK) - 64'd1);

  logic           v_r;
  geic_pkg::req_t req_r;

  assign in_ready = !v_r || q_ready;
  assign q_valid  = v_r;
  assign q_req    = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r.cmd     <= in_cmd;
      req_r.bank    <= in_bank;
      req_r.bank_ok <= 32'(in_bank) < NUM_BANKS;
      req_r.sel     <= in_reg_select;
      req_r.wdata   <= in_write_data & PIN_MASK;
      req_r.levels  <= in_pin_levels & PIN_MASK;
    end
  end
endmodule

[hdl/geic_back.sv]
// Back end: bank register file, sampling, claim encoder, result register.
// Depends on geic_pkg.
`timescale 1ns / 1ps
module geic_back #(
  parameter int NUM_BANKS     = geic_pkg::NUM_BANKS_DEF,
  parameter int PINS_PER_BANK = geic_pkg::PINS_PER_BANK_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  geic_pkg::req_t  q_req,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     out_read_data,
  output logic            out_irq_out,
  output logic            out_claim_valid,
  output logic [6:0]      out_claim_pin
);
  localparam int BW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

  logic [31:0] edge_r [NUM_BANKS];
  logic [31:0] polhi_r [NUM_BANKS];
  logic [31:0] pollo_r [NUM_BANKS];
  logic [31:0] en_r [NUM_BANKS];
  logic [31:0] stat_r [NUM_BANKS];
  logic [31:0] prev_r [NUM_BANKS];
  logic [31:0] edge_nxt [NUM_BANKS];
  logic [31:0] polhi_nxt [NUM_BANKS];
  logic [31:0] pollo_nxt [NUM_BANKS];
  logic [31:0] en_nxt [NUM_BANKS];
  logic [31:0] stat_nxt [NUM_BANKS];
  logic [31:0] prev_nxt [NUM_BANKS];

  logic        ov_r;
  logic [31:0] rd_r, rd_nxt;
  logic        irq_r, irq_nxt;
  logic        cv_r, cv_nxt;
  logic [6:0]  cp_r, cp_nxt;
  logic        go;
  logic [BW-1:0] b;

  assign q_ready = !ov_r || out_ready;
  assign go      = q_valid && q_ready;
  assign b       = q_req.bank[BW-1:0];

  always_comb begin
    logic [31:0] pend, rise, fall, eh, lh, hit;
    logic        found;
    edge_nxt  = edge_r;
    polhi_nxt = polhi_r;
    pollo_nxt = pollo_r;
    en_nxt    = en_r;
    stat_nxt  = stat_r;
    prev_nxt  = prev_r;
    rd_nxt = '0;
    cv_nxt = 1'b0;
    cp_nxt = '0;
    found  = 1'b0;
    pend   = '0;
    rise   = '0;
    fall   = '0;
    eh     = '0;
    lh     = '0;
    hit    = '0;
    unique case (q_req.cmd)
      geic_pkg::CMD_WRITE: begin
        if (q_req.bank_ok) begin
          unique case (q_req.sel)
            geic_pkg::SEL_TYPE:      edge_nxt[b] = q_req.wdata;
            geic_pkg::SEL_POLHI_SET: polhi_nxt[b] = polhi_r[b] | q_req.wdata;
            geic_pkg::SEL_POLHI_CLR: polhi_nxt[b] = polhi_r[b] & ~q_req.wdata;
            geic_pkg::SEL_POLLO_SET: pollo_nxt[b] = pollo_r[b] | q_req.wdata;
            geic_pkg::SEL_POLLO_CLR: pollo_nxt[b] = pollo_r[b] & ~q_req.wdata;
            geic_pkg::SEL_EN_SET:    en_nxt[b] = en_r[b] | q_req.wdata;
            geic_pkg::SEL_EN_CLR:    en_nxt[b] = en_r[b] & ~q_req.wdata;
            geic_pkg::SEL_ENABLE:    en_nxt[b] = q_req.wdata;
            geic_pkg::SEL_STATUS:    stat_nxt[b] = stat_r[b] & ~q_req.wdata;
            default: ;
          endcase
        end
      end
      geic_pkg::CMD_READ: begin
        if (q_req.bank_ok) begin
          unique case (q_req.sel)
            geic_pkg::SEL_TYPE: rd_nxt = edge_r[b];
            geic_pkg::SEL_POLHI_SET, geic_pkg::SEL_POLHI_CLR: rd_nxt = polhi_r[b];
            geic_pkg::SEL_POLLO_SET, geic_pkg::SEL_POLLO_CLR: rd_nxt = pollo_r[b];
            geic_pkg::SEL_EN_SET, geic_pkg::SEL_EN_CLR,
            geic_pkg::SEL_ENABLE: rd_nxt = en_r[b];
            geic_pkg::SEL_STATUS: rd_nxt = stat_r[b];
            default: rd_nxt = '0;
          endcase
        end
      end
      geic_pkg::CMD_SAMPLE: begin
        if (q_req.bank_ok) begin
          rise = ~prev_r[b] & q_req.levels;
          fall = prev_r[b] & ~q_req.levels;
          eh = (rise & polhi_r[b]) | (fall & pollo_r[b]);
          lh = (q_req.levels & polhi_r[b]) | (~q_req.levels & pollo_r[b]);
          hit = (edge_r[b] & eh) | (~edge_r[b] & lh);
          stat_nxt[b] = stat_r[b] | hit;
          prev_nxt[b] = q_req.levels;
        end
      end
      default: begin
        // Claim: lowest pending enabled pin, bank 0 first.
        for (int k = 0; k < NUM_BANKS; k++) begin
          pend = stat_r[k] & en_r[k];
          for (int i = 0; i < PINS_PER_BANK; i++) begin
            if (!found && pend[i]) begin
              found = 1'b1;
              stat_nxt[k][i] = 1'b0;
              cp_nxt = 7'(k * geic_pkg::BANK_STRIDE + i);
            end
          end
        end
        cv_nxt = found;
      end
    endcase
    irq_nxt = 1'b0;
    for (int k = 0; k < NUM_BANKS; k++) begin
      irq_nxt = irq_nxt | (|(stat_nxt[k] & en_nxt[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      for (int k = 0; k < NUM_BANKS; k++) begin
        edge_r[k]  <= '0;
        polhi_r[k] <= '0;
        pollo_r[k] <= '0;
        en_r[k]    <= '0;
        stat_r[k]  <= '0;
        prev_r[k]  <= '0;
      end
    end else begin
      if (q_ready) begin
        ov_r <= q_valid;
      end
      if (go) begin
        edge_r  <= edge_nxt;
        polhi_r <= polhi_nxt;
        pollo_r <= pollo_nxt;
        en_r    <= en_nxt;
        stat_r  <= stat_nxt;
        prev_r  <= prev_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rd_r  <= rd_nxt;
      irq_r <= irq_nxt;
      cv_r  <= cv_nxt;
      cp_r  <= cp_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_read_data   = rd_r;
  assign out_irq_out     = irq_r;
  assign out_claim_valid = cv_r;
  assign out_claim_pin   = cp_r;
endmodule

[hdl/gpio_edge_interrupt_controller.sv]
// Banked GPIO edge/level interrupt controller, top level.
// Requests enter on in_ch; one result per request leaves on out_ch.
// Commands: register write, register read, sample a bank's pin levels,
// claim the lowest pending enabled pin (clears its status).
// Each result carries read data (zero unless a read), irq_out after the
// request, and the claim outcome.
// The front register holds an accepted request, then the back-end result
// register holds its result. Throughput: one request per cycle while out_ch
// is ready; the back end's register update plus the 96-pin claim encoder sets it.
// The front register acts as a one-deep queue, so either side stalls
// alone. When the receiver stalls, results hold and the front fills,
// then in_ch.ready drops. Synchronous reset clears all bank registers
// and empties both stages.
// Depends on geic_pkg, geic_if, geic_front, geic_back.
`timescale 1ns / 1ps
module gpio_edge_interrupt_controller #(
  parameter int NUM_BANKS     = geic_pkg::NUM_BANKS_DEF,
  parameter int PINS_PER_BANK = geic_pkg::PINS_PER_BANK_DEF
) (
  input logic     clk,
  input logic     rst_n,
  geic_in_if.sink   in_ch,
  geic_out_if.source out_ch
);
  logic           q_valid, q_ready;
  geic_pkg::req_t q_req;

  // Accept and decode.
  geic_front #(.NUM_BANKS(NUM_BANKS), .PINS_PER_BANK(PINS_PER_BANK)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_cmd(in_ch.cmd), .in_bank(in_ch.bank), .in_reg_select(in_ch.reg_select),
    .in_write_data(in_ch.write_data), .in_pin_levels(in_ch.pin_levels),
    .q_valid, .q_ready, .q_req
  );

  // Execute against bank state and register the result.
  geic_back #(.NUM_BANKS(NUM_BANKS), .PINS_PER_BANK(PINS_PER_BANK)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_req,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_read_data(out_ch.read_data), .out_irq_out(out_ch.irq_out),
    .out_claim_valid(out_ch.claim_valid), .out_claim_pin(out_ch.claim_pin)
  );
endmodule

[hdl/geic_checker.sv]
// Port-level checker for the controller, bound to the top level.
// Depends on geic_if.
`timescale 1ns / 1ps
module geic_checker (
  input logic clk,
  input logic rst_n,
  geic_in_if.sink   in_ch,
  geic_out_if.source out_ch
);
  // A result never claims without naming a pin in range.
  a_pin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.claim_valid |-> out_ch.claim_pin < 7'd96)
    else $error("claim pin out of range");
  // The claim pin stays zero when no claim is reported.
  a_pin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.claim_valid |-> out_ch.claim_pin == 7'd0)
    else $error("claim pin set without claim");
  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.read_data))
    else $error("result dropped under stall");
  // Nothing appears at the output without an earlier request.
  a_no_spur: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(in_ch.valid, 2))
    else $error("result without request");
endmodule

bind gpio_edge_interrupt_controller geic_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
);

[bench/gpio_edge_interrupt_controller_test.sv]
// Testbench for the banked GPIO interrupt controller: register access, pin
// sampling in edge and level modes, claims, and irq after every request.
// Depends on geic_pkg, geic_if and the gpio_edge_interrupt_controller RTL.
`timescale 1ns / 1ps
module gpio_edge_interrupt_controller_test;
  localparam int NB = 3;

  typedef struct {
    logic [1:0]  cmd;
    logic [1:0]  bank;
    logic [3:0]  sel;
    logic [31:0] wdata;
    logic [31:0] levels;
  } request_t;

  typedef struct {
    logic [31:0] read_data;
    logic        irq_out;
    logic        claim_valid;
    logic [6:0]  claim_pin;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  geic_in_if  in_ch ();
  geic_out_if out_ch ();

  gpio_edge_interrupt_controller u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  // Shadow copy of the bank registers.
  logic [31:0] sh_type [NB];
  logic [31:0] sh_polhi [NB];
  logic [31:0] sh_pollo [NB];
  logic [31:0] sh_en [NB];
  logic [31:0] sh_status [NB];
  logic [31:0] sh_prev [NB];

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int errors = 0;
  int n_results = 0;
  int n_claims_hit = 0;
  bit calm = 1'b0;   // no idling in the last part
  bit stim_done = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    errors++;
    $display("MISMATCH result %0d %s: got %0h expected %0h", n_results, what, got, exp);
  endtask

  // Advance the shadow state by one request and return the result it yields.
  function automatic result_t predict_gpio(input request_t r);
    result_t res;
    logic [31:0] prev, rise, fall, eh, lh;
    bit found;
    int b;
    res = '{default: '0};
    b = r.bank;
    found = 1'b0;
    case (r.cmd)
      geic_pkg::CMD_WRITE: if (b < NB) begin
        case (r.sel)
          geic_pkg::SEL_TYPE:      sh_type[b] = r.wdata;
          geic_pkg::SEL_POLHI_SET: sh_polhi[b] |= r.wdata;
          geic_pkg::SEL_POLHI_CLR: sh_polhi[b] &= ~r.wdata;
          geic_pkg::SEL_POLLO_SET: sh_pollo[b] |= r.wdata;
          geic_pkg::SEL_POLLO_CLR: sh_pollo[b] &= ~r.wdata;
          geic_pkg::SEL_EN_SET:    sh_en[b] |= r.wdata;
          geic_pkg::SEL_EN_CLR:    sh_en[b] &= ~r.wdata;
          geic_pkg::SEL_ENABLE:    sh_en[b] = r.wdata;
          geic_pkg::SEL_STATUS:    sh_status[b] &= ~r.wdata;
          default: ;
        endcase
      end
      geic_pkg::CMD_READ: if (b < NB) begin
        case (r.sel)
          geic_pkg::SEL_TYPE: res.read_data = sh_type[b];
          geic_pkg::SEL_POLHI_SET, geic_pkg::SEL_POLHI_CLR: res.read_data = sh_polhi[b];
          geic_pkg::SEL_POLLO_SET, geic_pkg::SEL_POLLO_CLR: res.read_data = sh_pollo[b];
          geic_pkg::SEL_EN_SET, geic_pkg::SEL_EN_CLR,
          geic_pkg::SEL_ENABLE: res.read_data = sh_en[b];
          geic_pkg::SEL_STATUS: res.read_data = sh_status[b];
          default: res.read_data = '0;
        endcase
      end
      geic_pkg::CMD_SAMPLE: if (b < NB) begin
        prev = sh_prev[b];
        rise = ~prev & r.levels;
        fall = prev & ~r.levels;
        eh = (rise & sh_polhi[b]) | (fall & sh_pollo[b]);
        lh = (r.levels & sh_polhi[b]) | (~r.levels & sh_pollo[b]);
        sh_status[b] |= (sh_type[b] & eh) | (~sh_type[b] & lh);
        sh_prev[b] = r.levels;
      end
      default: begin
        // Claim scans every bank from pin 0 upward, bank field ignored.
        for (int k = 0; k < NB && !found; k++)
          for (int i = 0; i < 32 && !found; i++)
            if (sh_status[k][i] && sh_en[k][i]) begin
              sh_status[k][i] = 1'b0;
              found = 1'b1;
              res.claim_valid = 1'b1;
              res.claim_pin = 7'(k * 32 + i);
            end
      end
    endcase
    for (int k = 0; k < NB; k++)
      if ((sh_status[k] & sh_en[k]) != 0) res.irq_out = 1'b1;
    return res;
  endfunction

  function automatic request_t mk(input logic [1:0] c, input logic [1:0] b,
                                 input logic [3:0] s, input logic [31:0] d,
                                 input logic [31:0] l);
    request_t r;
    r.cmd = c; r.bank = b; r.sel = s; r.wdata = d; r.levels = l;
    return r;
  endfunction

  function automatic request_t rand_req();
    request_t r;
    int p;
    p = $urandom_range(0, 99);
    r.bank = (p < 95) ? 2'($urandom_range(0, 2)) : 2'd3;
    r.wdata = $urandom();
    r.levels = $urandom();
    r.sel = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
    // Bias toward samples and claims so interrupts actually fire.
    if (p < 25) r.cmd = geic_pkg::CMD_WRITE;
    else if (p < 45) r.cmd = geic_pkg::CMD_READ;
    else if (p < 75) r.cmd = geic_pkg::CMD_SAMPLE;
    else r.cmd = geic_pkg::CMD_CLAIM;
    if ($urandom_range(0, 3) == 0) r.levels = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    return r;
  endfunction

  // Driver: hold the request until accepted, idle in random bursts.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(0, 12);
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        request_t r;
        r = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= r.cmd;
        in_ch.bank <= r.bank;
        in_ch.reg_select <= r.sel;
        in_ch.write_data <= r.wdata;
        in_ch.pin_levels <= r.levels;
        expected_results.push_back(predict_gpio(r));
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stalls and result checking.
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        result_t e;
        n_results++;
        if (expected_results.size() == 0) begin
          report("unexpected result", out_ch.read_data, 32'd0);
        end else begin
          e = expected_results.pop_front();
          if (out_ch.read_data !== e.read_data) report("read_data", out_ch.read_data, e.read_data);
          if (out_ch.irq_out !== e.irq_out)
            report("irq_out", 32'(out_ch.irq_out), 32'(e.irq_out));
          if (out_ch.claim_valid !== e.claim_valid)
            report("claim_valid", 32'(out_ch.claim_valid), 32'(e.claim_valid));
          if (out_ch.claim_pin !== e.claim_pin)
            report("claim_pin", 32'(out_ch.claim_pin), 32'(e.claim_pin));
          if (e.claim_valid) n_claims_hit++;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(0, 12);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = geic_pkg::CMD_READ;
    in_ch.bank = '0;
    in_ch.reg_select = geic_pkg::SEL_TYPE;
    in_ch.write_data = '0;
    in_ch.pin_levels = '0;
    out_ch.ready = 1'b0;
    for (int k = 0; k < NB; k++) begin
      sh_type[k] = '0; sh_polhi[k] = '0; sh_pollo[k] = '0;
      sh_en[k] = '0; sh_status[k] = '0; sh_prev[k] = '0;
    end
    // Directed: every register, edge and level modes, claim on empty,
    // out-of-range bank, unknown select, extremes of data.
    pending_reqs.push_back(mk(geic_pkg::CMD_CLAIM, 2'd0, geic_pkg::SEL_TYPE, '0, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_WRITE, 2'd0, geic_pkg::SEL_POLHI_SET,
                              32'hFFFF_FFFF, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_WRITE, 2'd0, geic_pkg::SEL_ENABLE,
                              32'hFFFF_FFFF, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_SAMPLE, 2'd0, geic_pkg::SEL_TYPE, '0,
                              32'h8000_0001));
    pending_reqs.push_back(mk(geic_pkg::CMD_READ, 2'd0, geic_pkg::SEL_STATUS, '0, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_CLAIM, 2'd2, geic_pkg::SEL_TYPE, '0, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_WRITE, 2'd0, geic_pkg::SEL_STATUS,
                              32'hFFFF_FFFF, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_WRITE, 2'd2, geic_pkg::SEL_TYPE,
                              32'hFFFF_FFFF, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_WRITE, 2'd2, geic_pkg::SEL_POLLO_SET,
                              32'hFFFF_FFFF, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_WRITE, 2'd2, geic_pkg::SEL_EN_SET,
                              32'h8000_0000, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_SAMPLE, 2'd2, geic_pkg::SEL_TYPE, '0,
                              32'hFFFF_FFFF));
    pending_reqs.push_back(mk(geic_pkg::CMD_SAMPLE, 2'd2, geic_pkg::SEL_TYPE, '0, 32'h0));
    pending_reqs.push_back(mk(geic_pkg::CMD_CLAIM, 2'd0, geic_pkg::SEL_TYPE, '0, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_CLAIM, 2'd0, geic_pkg::SEL_TYPE, '0, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_WRITE, 2'd2, geic_pkg::SEL_POLLO_CLR,
                              32'h0000_FFFF, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_WRITE, 2'd0, geic_pkg::SEL_POLHI_CLR,
                              32'hFFFF_0000, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_WRITE, 2'd0, geic_pkg::SEL_EN_CLR,
                              32'h5555_5555, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_READ, 2'd0, geic_pkg::SEL_EN_SET, '0, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_READ, 2'd2, geic_pkg::SEL_POLLO_CLR, '0, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_READ, 2'd0, geic_pkg::SEL_POLHI_SET, '0, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_WRITE, 2'd3, geic_pkg::SEL_ENABLE,
                              32'hFFFF_FFFF, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_READ, 2'd3, geic_pkg::SEL_ENABLE, '0, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_SAMPLE, 2'd3, geic_pkg::SEL_TYPE, '0,
                              32'hFFFF_FFFF));
    pending_reqs.push_back(mk(geic_pkg::CMD_WRITE, 2'd1, 4'd15, 32'hFFFF_FFFF, '0));
    pending_reqs.push_back(mk(geic_pkg::CMD_READ, 2'd1, 4'd12, '0, '0));
    for (int i = 0; i < 700; i++) pending_reqs.push_back(rand_req());
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() < 120);
    calm = 1'b1;
    wait (pending_reqs.size() == 0 && expected_results.size() == 0);
    repeat (10) @(posedge clk);
    $display("Ran %0d requests across all commands, register selects and banks;", n_results);
    $display("%0d claims returned a pending pin.", n_claims_hit);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected", expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
